/* design/hdts_pkg.sv */
// ----------------------------------------------------------------------------
// hdts_pkg
// Shared types and constants for the hop delay time sync accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package hdts_pkg;

  // running sum width (8 to 16)
  localparam int TIME_BITS   = 14;
  localparam int TIME_LOW_W  = 14;
  localparam int TIME_EXT_W  = (TIME_BITS > TIME_LOW_W) ? TIME_BITS : TIME_LOW_W;

  localparam int STAMP_W     = 16;
  localparam int OFFSET_W    = 16;
  localparam int DELAY_W     = 17;
  // raw difference plus offset needs one bit more than the halved delay
  localparam int RAW_W       = DELAY_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [RAW_W-1:0] NEG_WRAP_ADD = RAW_W'(16'h3fff);

  typedef enum logic [1:0] {
    NODE_FDU  = 2'd0,
    NODE_LCI  = 2'd1,
    NODE_LAUX = 2'd2,
    NODE_LAUL = 2'd3
  } node_type_t;

  typedef enum logic [1:0] {
    DIR_TOP   = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } route_dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUTE_DIRECTION    = 3'd0,
    REG_OFFSET_FDU_TO_FDU  = 3'd1,
    REG_OFFSET_LCI_TO_FDU  = 3'd2,
    REG_OFFSET_FDU_TO_LAUL = 3'd3,
    REG_OFFSET_LAUL_TO_FDU = 3'd4,
    REG_DELAY_LIMIT        = 3'd5,
    REG_DELAY_DEFAULT      = 3'd6,
    REG_SAMPLING_ACTIVE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    route_dir_t                  route_direction;
    logic signed [OFFSET_W-1:0]  offset_fdu_to_fdu;
    logic signed [OFFSET_W-1:0]  offset_lci_to_fdu;
    logic signed [OFFSET_W-1:0]  offset_fdu_to_laul;
    logic signed [OFFSET_W-1:0]  offset_laul_to_fdu;
    logic signed [DELAY_W-1:0]   delay_limit;
    logic signed [DELAY_W-1:0]   delay_default;
    logic                        sampling_active;
  } hdts_cfg_t;

  typedef struct packed {
    logic                route_start;
    node_type_t          upstream_type;
    node_type_t          downstream_type;
    logic [STAMP_W-1:0]  recv_top;
    logic [STAMP_W-1:0]  recv_down;
    logic [STAMP_W-1:0]  recv_left;
    logic [STAMP_W-1:0]  recv_right;
    logic [STAMP_W-1:0]  recv_plain;
    logic [STAMP_W-1:0]  downstream_send;
    logic                downstream_acked;
  } hop_item_t;

  typedef struct packed {
    logic signed [DELAY_W-1:0]  hop_delay;
    logic [TIME_LOW_W-1:0]      time_low;
    logic                       set_frame_due;
  } hop_result_t;

endpackage

`default_nettype wire

/* design/hdts_if.sv */
// ----------------------------------------------------------------------------
// hdts_if
// Valid/ready channels for hop words in and hop results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdts_in_if;
  logic        valid;
  logic        ready;
  logic        route_start;
  logic [1:0]  upstream_type;
  logic [1:0]  downstream_type;
  logic [15:0] recv_top;
  logic [15:0] recv_down;
  logic [15:0] recv_left;
  logic [15:0] recv_right;
  logic [15:0] recv_plain;
  logic [15:0] downstream_send;
  logic        downstream_acked;

  modport source (
    output valid, route_start, upstream_type, downstream_type, recv_top, recv_down,
           recv_left, recv_right, recv_plain, downstream_send, downstream_acked,
    input  ready
  );
  modport sink (
    input  valid, route_start, upstream_type, downstream_type, recv_top, recv_down,
           recv_left, recv_right, recv_plain, downstream_send, downstream_acked,
    output ready
  );
  modport mon (
    input valid, ready, route_start, upstream_type, downstream_type, recv_top,
          recv_down, recv_left, recv_right, recv_plain, downstream_send,
          downstream_acked
  );
endinterface

interface hdts_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] hop_delay;
  logic [13:0]        time_low;
  logic               set_frame_due;

  modport source (
    output valid, hop_delay, time_low, set_frame_due,
    input  ready
  );
  modport sink (
    input  valid, hop_delay, time_low, set_frame_due,
    output ready
  );
  modport mon (
    input valid, ready, hop_delay, time_low, set_frame_due
  );
endinterface

`default_nettype wire

/* design/hdts_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hdts_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module hdts_cfg_regs
  import hdts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output hdts_cfg_t                  cfg
);

  hdts_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ROUTE_DIRECTION:    cfg_r.route_direction    <= route_dir_t'(cfg_wdata[1:0]);
        REG_OFFSET_FDU_TO_FDU:  cfg_r.offset_fdu_to_fdu  <= cfg_wdata[OFFSET_W-1:0];
        REG_OFFSET_LCI_TO_FDU:  cfg_r.offset_lci_to_fdu  <= cfg_wdata[OFFSET_W-1:0];
        REG_OFFSET_FDU_TO_LAUL: cfg_r.offset_fdu_to_laul <= cfg_wdata[OFFSET_W-1:0];
        REG_OFFSET_LAUL_TO_FDU: cfg_r.offset_laul_to_fdu <= cfg_wdata[OFFSET_W-1:0];
        REG_DELAY_LIMIT:        cfg_r.delay_limit        <= cfg_wdata[DELAY_W-1:0];
        REG_DELAY_DEFAULT:      cfg_r.delay_default      <= cfg_wdata[DELAY_W-1:0];
        REG_SAMPLING_ACTIVE:    cfg_r.sampling_active    <= cfg_wdata[0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* design/hdts_hop_calc.sv */
// ----------------------------------------------------------------------------
// hdts_hop_calc
// Hop delay arithmetic: select, subtract, wrap, offset, halve, limit, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module hdts_hop_calc
  import hdts_pkg::*;
(
  input  wire hop_item_t             item,
  input  wire hdts_cfg_t             cfg,
  input  wire logic [TIME_BITS-1:0]  sum_cur,
  output logic [TIME_BITS-1:0]       sum_nxt,
  output hop_result_t                res
);

  logic [STAMP_W-1:0]        recv;
  logic signed [RAW_W-1:0]   diff;
  logic signed [RAW_W-1:0]   wrapped;
  logic signed [OFFSET_W-1:0] offset;
  logic signed [RAW_W-1:0]   comp;
  logic signed [DELAY_W-1:0] halved;
  logic signed [DELAY_W-1:0] delay;
  logic [TIME_BITS-1:0]      sum_base;
  logic [TIME_EXT_W-1:0]     sum_ext;

  always_comb begin
    // stations pick the receive time on the side the route runs along
    if (item.upstream_type == NODE_LCI || item.upstream_type == NODE_LAUX) begin
      unique case (cfg.route_direction)
        DIR_TOP:   recv = item.recv_top;
        DIR_DOWN:  recv = item.recv_down;
        DIR_LEFT:  recv = item.recv_left;
        DIR_RIGHT: recv = item.recv_right;
      endcase
    end else begin
      recv = item.recv_plain;
    end

    diff    = RAW_W'({2'b00, recv}) - RAW_W'({2'b00, item.downstream_send});
    wrapped = diff[RAW_W-1] ? diff + NEG_WRAP_ADD : diff;

    priority if (item.upstream_type == NODE_FDU && item.downstream_type == NODE_FDU) begin
      offset = cfg.offset_fdu_to_fdu;
    end else if (item.upstream_type == NODE_LCI && item.downstream_type == NODE_FDU) begin
      offset = cfg.offset_lci_to_fdu;
    end else if (item.upstream_type == NODE_FDU && item.downstream_type == NODE_LAUL) begin
      offset = cfg.offset_fdu_to_laul;
    end else if (item.upstream_type == NODE_LAUL && item.downstream_type == NODE_FDU) begin
      offset = cfg.offset_laul_to_fdu;
    end else begin
      offset = '0;
    end

    comp   = wrapped + RAW_W'(offset);
    // floor halving: drop the low bit of the two's complement value
    halved = comp[RAW_W-1:1];
    delay  = (halved > cfg.delay_limit) ? cfg.delay_default : halved;

    sum_base = item.route_start ? '0 : sum_cur;
    sum_nxt  = TIME_BITS'(sum_base + delay[TIME_BITS-1:0]);
    sum_ext  = TIME_EXT_W'(sum_nxt);

    res.hop_delay     = delay;
    res.time_low      = sum_ext[TIME_LOW_W-1:0];
    res.set_frame_due = !cfg.sampling_active || !item.downstream_acked;
  end

endmodule

`default_nettype wire

/* design/hop_delay_time_sync_accumulator.sv */
// ----------------------------------------------------------------------------
// hop_delay_time_sync_accumulator
// Per-hop delay compensation and running time sum for line time sync.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    one hop: node types, receive/send times, ack
//   out_ch   out  valid/ready    hop_delay, time_low, set_frame_due
//   cfg_*    in   cfg_we only    register index and write data
//
// one hop word per cycle while the result is not stalled; the path runs through
// the input register, then the arithmetic into the result register with the sum
// the running sum updates as a result is loaded, so hops chain back to back
// synchronous reset clears valids, the running sum and the config registers
// a stalled result holds; the input register still takes a word when the
// result register frees up in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hop_delay_time_sync_accumulator
  import hdts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  hdts_in_if.sink                    in_ch,
  hdts_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  hdts_cfg_t            cfg;
  hop_item_t            item_r;
  logic                 item_vld_r;
  hop_result_t          res_r;
  hop_result_t          res_nxt;
  logic                 res_vld_r;
  logic [TIME_BITS-1:0] sum_r;
  logic [TIME_BITS-1:0] sum_nxt;
  logic                 advance;
  logic                 in_take;

  hdts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hdts_hop_calc u_calc (
    .item    (item_r),
    .cfg     (cfg),
    .sum_cur (sum_r),
    .sum_nxt (sum_nxt),
    .res     (res_nxt)
  );

  assign advance     = item_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      sum_r      <= '0;
    end else begin
      item_vld_r <= in_take || (item_vld_r && !advance);
      if (advance) begin
        res_vld_r <= 1'b1;
        sum_r     <= sum_nxt;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.route_start      <= in_ch.route_start;
      item_r.upstream_type    <= node_type_t'(in_ch.upstream_type);
      item_r.downstream_type  <= node_type_t'(in_ch.downstream_type);
      item_r.recv_top         <= in_ch.recv_top;
      item_r.recv_down        <= in_ch.recv_down;
      item_r.recv_left        <= in_ch.recv_left;
      item_r.recv_right       <= in_ch.recv_right;
      item_r.recv_plain       <= in_ch.recv_plain;
      item_r.downstream_send  <= in_ch.downstream_send;
      item_r.downstream_acked <= in_ch.downstream_acked;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = res_vld_r;
  assign out_ch.hop_delay     = res_r.hop_delay;
  assign out_ch.time_low      = res_r.time_low;
  assign out_ch.set_frame_due = res_r.set_frame_due;

endmodule

`default_nettype wire

/* design/hdts_checker.sv */
// ----------------------------------------------------------------------------
// hdts_checker
// Port-level checks on the accumulator, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module hdts_checker
  import hdts_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [DELAY_W-1:0] out_hop_delay,
  input wire logic [TIME_LOW_W-1:0]     out_time_low,
  input wire logic                      out_set_frame_due
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // stalled result word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_hop_delay) && $stable(out_time_low) &&
      $stable(out_set_frame_due))
    else $error("result changed while stalled");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result out of an empty pipe comes from a word taken into the input register
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result without input word");

  // an empty pipe always takes a word
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_acc) |-> in_ready)
    else $error("ready low with empty pipe");

endmodule

bind hop_delay_time_sync_accumulator hdts_checker u_hdts_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_hop_delay     (out_ch.hop_delay),
  .out_time_low      (out_ch.time_low),
  .out_set_frame_due (out_ch.set_frame_due)
);

`default_nettype wire
